/* design/nrcc_pkg.sv */
// Package with shared types and fixed-point constants of the color classifier.
`timescale 1ns / 1ps
package nrcc_pkg;

  // Cylinder coordinates in hundredths, signed.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } coord_t;

  // One stored reference: valid flag, precomputed coordinates and intensity.
  typedef struct packed {
    logic               valid;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        z;
  } entry_t;

  localparam int unsigned EntryW = 48;

  localparam logic [17:0] AngleStep  = 18'd187403;
  localparam logic [30:0] OneQ30     = 31'h4000_0000;
  localparam logic [15:0] FullTurn   = 16'd36000;
  localparam logic [34:0] LimitSq    = 35'd10000000000;

  // Reciprocals for exact truncating division of values below 2^30.
  localparam logic [30:0] Recip6     = 31'd1431655766;  // shift 33
  localparam logic [30:0] Recip120   = 31'd1145324613;  // shift 37
  localparam logic [30:0] Recip5040  = 31'd1745256553;  // shift 43
  localparam logic [30:0] Recip24    = 31'd1431655766;  // shift 35
  localparam logic [30:0] Recip720   = 31'd1527099484;  // shift 40
  localparam logic [30:0] Recip40320 = 31'd1745256553;  // shift 46

endpackage

/* design/nrcc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module nrcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  logic [WIDTH-1:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_i,
  output logic [WIDTH-1:0]               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/nrcc_cyl.sv */
// Sequential hue/saturation to cylinder coordinate unit on one shared multiplier.
`timescale 1ns / 1ps
module nrcc_cyl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [15:0]          hue_i,
  input  logic [13:0]          sat_i,
  output logic                 done_o,
  output nrcc_pkg::coord_t     coord_o
);

  localparam logic [4:0] LastStep = 5'd16;

  logic        busy_q, done_q;
  logic [4:0]  step_q;
  logic [29:0] p_q [1:8];
  logic [29:0] p_d [1:8];
  logic [12:0] r_q;
  logic        swap_q;
  logic [1:0]  quad_q;
  logic [13:0] sat_q;
  logic [30:0] csm_q, snm_q, csm_d, snm_d;
  logic        csn_q, snn_q, csn_d, snn_d;
  logic signed [15:0] px_q, py_q, px_d, py_d;

  logic [30:0] mul_a, mul_b;
  logic [61:0] prod, prod_rnd;
  logic [15:0] hred;
  logic [1:0]  quad_d;
  logic [13:0] rem_d;
  logic [12:0] r_d;
  logic signed [32:0] sinp, cosp;
  logic [30:0] sin_m, cos_m, a_m, b_m;
  logic [14:0] v_mag;

  assign prod     = 62'(mul_a) * 62'(mul_b);
  assign prod_rnd = prod + 62'h2000_0000;
  assign v_mag    = prod_rnd[44:30];

  // Quadrant and octant reduction of the incoming hue.
  always_comb begin
    hred = (hue_i >= nrcc_pkg::FullTurn) ? hue_i - nrcc_pkg::FullTurn : hue_i;
    if (hred >= 16'd27000) begin
      quad_d = 2'd3; rem_d = 14'(hred - 16'd27000);
    end else if (hred >= 16'd18000) begin
      quad_d = 2'd2; rem_d = 14'(hred - 16'd18000);
    end else if (hred >= 16'd9000) begin
      quad_d = 2'd1; rem_d = 14'(hred - 16'd9000);
    end else begin
      quad_d = 2'd0; rem_d = hred[13:0];
    end
    r_d = (rem_d > 14'd4500) ? 13'(14'd9000 - rem_d) : rem_d[12:0];
  end

  // Series sums; every power term is nonnegative and below 2^30.
  always_comb begin
    sinp = 33'(p_q[1]) - 33'(p_q[3]) + 33'(p_q[5]) - 33'(p_q[7]);
    cosp = 33'(nrcc_pkg::OneQ30) - 33'(p_q[2] >> 1) + 33'(p_q[4]) - 33'(p_q[6])
           + 33'(p_q[8]);
    sin_m = sinp[30:0];
    cos_m = cosp[30:0];
    a_m = swap_q ? cos_m : sin_m;
    b_m = swap_q ? sin_m : cos_m;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    p_d   = p_q;
    csm_d = csm_q; snm_d = snm_q; csn_d = csn_q; snn_d = snn_q;
    px_d  = px_q;  py_d  = py_q;
    unique case (step_q)
      5'd0:  begin mul_a = 31'(r_q);   mul_b = 31'(nrcc_pkg::AngleStep);
                   p_d[1] = prod[29:0]; end
      5'd1:  begin mul_a = 31'(p_q[1]); mul_b = 31'(p_q[1]); p_d[2] = prod[59:30]; end
      5'd2:  begin mul_a = 31'(p_q[2]); mul_b = 31'(p_q[1]); p_d[3] = prod[59:30]; end
      5'd3:  begin mul_a = 31'(p_q[2]); mul_b = 31'(p_q[2]); p_d[4] = prod[59:30]; end
      5'd4:  begin mul_a = 31'(p_q[4]); mul_b = 31'(p_q[1]); p_d[5] = prod[59:30]; end
      5'd5:  begin mul_a = 31'(p_q[4]); mul_b = 31'(p_q[2]); p_d[6] = prod[59:30]; end
      5'd6:  begin mul_a = 31'(p_q[6]); mul_b = 31'(p_q[1]); p_d[7] = prod[59:30]; end
      5'd7:  begin mul_a = 31'(p_q[4]); mul_b = 31'(p_q[4]); p_d[8] = prod[59:30]; end
      5'd8:  begin mul_a = 31'(p_q[3]); mul_b = nrcc_pkg::Recip6;
                   p_d[3] = 30'(prod[61:33]); end
      5'd9:  begin mul_a = 31'(p_q[5]); mul_b = nrcc_pkg::Recip120;
                   p_d[5] = 30'(prod[61:37]); end
      5'd10: begin mul_a = 31'(p_q[7]); mul_b = nrcc_pkg::Recip5040;
                   p_d[7] = 30'(prod[61:43]); end
      5'd11: begin mul_a = 31'(p_q[4]); mul_b = nrcc_pkg::Recip24;
                   p_d[4] = 30'(prod[61:35]); end
      5'd12: begin mul_a = 31'(p_q[6]); mul_b = nrcc_pkg::Recip720;
                   p_d[6] = 30'(prod[61:40]); end
      5'd13: begin mul_a = 31'(p_q[8]); mul_b = nrcc_pkg::Recip40320;
                   p_d[8] = 30'(prod[61:46]); end
      5'd14: begin
        // Quadrant sets which octant value lands where and with which sign.
        unique case (quad_q)
          2'd0: begin snm_d = a_m; snn_d = 1'b0; csm_d = b_m; csn_d = 1'b0; end
          2'd1: begin snm_d = b_m; snn_d = 1'b0; csm_d = a_m; csn_d = 1'b1; end
          2'd2: begin snm_d = a_m; snn_d = 1'b1; csm_d = b_m; csn_d = 1'b1; end
          default: begin snm_d = b_m; snn_d = 1'b1; csm_d = a_m; csn_d = 1'b0; end
        endcase
      end
      5'd15: begin
        mul_a = 31'(sat_q); mul_b = csm_q;
        px_d = csn_q ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});
      end
      5'd16: begin
        mul_a = 31'(sat_q); mul_b = snm_q;
        py_d = snn_q ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == LastStep);
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
        end
        step_q <= step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      r_q    <= r_d;
      swap_q <= (rem_d > 14'd4500);
      quad_q <= quad_d;
      sat_q  <= sat_i;
    end else if (busy_q) begin
      p_q   <= p_d;
      csm_q <= csm_d; snm_q <= snm_d; csn_q <= csn_d; snn_q <= snn_d;
      px_q  <= px_d;  py_q  <= py_d;
    end
  end

  assign done_o    = done_q;
  assign coord_o.x = px_q;
  assign coord_o.y = py_q;

endmodule

/* design/nearest_reference_color_classifier.sv */
// Top level of the nearest reference color classifier.
//
//  Channel   Dir  Signals                         Content
//  s_axis    in   tvalid tready tdata[55:0] tuser  write entry or query color
//  m_axis    out  tvalid tready tdata[7:0]         nearest level and match flag
//
// A write runs the coordinate unit on its shared multiplier, then one RAM write. A
// query runs the same coordinate work, then a read, square and compare step per
// stored level. After reset the block sweeps all NUM_STRIPS * NUM_LEVELS table
// entries, writing empty entries, and accepts no transaction meanwhile. A stalled
// result sits in the output register while the next transaction is already accepted
// and processed.
`timescale 1ns / 1ps
module nearest_reference_color_classifier #(
  parameter int unsigned NUM_STRIPS = 16,
  parameter int unsigned NUM_LEVELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // strip[3:0], level_slot[6:4], hue[22:7], saturation[36:23], intensity[51:37]
  input  logic [55:0] s_axis_tdata_i,
  // op[0]: 0 writes an entry, 1 classifies a query
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // level[2:0], matched[3]
  output logic [7:0]  m_axis_tdata_o
);

  localparam int unsigned Depth = NUM_STRIPS * NUM_LEVELS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned LW    = $clog2(NUM_LEVELS + 1);

  // Sequencer states.
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StCyl   = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StSq    = 3'd4;
  localparam logic [2:0] StCmp   = 3'd5;
  localparam logic [2:0] StRes   = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [LW-1:0] lvl_q;

  // Transaction fields held while the item is worked on.
  logic        op_q;
  logic [3:0]  strip_q;
  logic [2:0]  slot_q;
  logic [15:0] hue_q;
  logic [13:0] sat_q;
  logic [14:0] int_q;

  logic        out_valid_q;
  logic [2:0]  out_level_q, res_level_q;
  logic        out_match_q, res_match_q;

  logic [34:0] best_q;
  logic [32:0] sqx_q, sqy_q, sqz_q;
  logic        ent_valid_q;

  logic        cyl_start, cyl_done;
  nrcc_pkg::coord_t cyl_coord;
  nrcc_pkg::coord_t q_coord_q;

  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [nrcc_pkg::EntryW-1:0] wdata, rdata;
  nrcc_pkg::entry_t    wentry, rentry;

  logic        accept;
  logic        strip_ok, slot_ok;
  logic [AW-1:0] base_addr;
  logic signed [16:0] dx, dy, dz;
  logic [34:0] dist_sq;
  logic        last_lvl;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign strip_ok = (32'(strip_q) < NUM_STRIPS);
  assign slot_ok  = (32'(slot_q) < NUM_LEVELS);
  assign base_addr = AW'(32'(strip_q) * NUM_LEVELS);
  assign last_lvl = (32'(lvl_q) == NUM_LEVELS - 1);

  assign cyl_start = (state_q == StIdle) && accept;

  nrcc_cyl u_cyl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cyl_start),
    .hue_i   (s_axis_tdata_i[22:7]),
    .sat_i   (s_axis_tdata_i[36:23]),
    .done_o  (cyl_done),
    .coord_o (cyl_coord)
  );

  // Table write: the clearing sweep, or a reference entry once its coordinates exist.
  always_comb begin
    wentry.valid = (hue_q != '0) || (sat_q != '0) || (int_q != '0);
    wentry.x     = cyl_coord.x;
    wentry.y     = cyl_coord.y;
    wentry.z     = int_q;
    if (state_q == StClear) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we    = (state_q == StCyl) && cyl_done && !op_q && strip_ok && slot_ok;
      waddr = base_addr + AW'(slot_q);
      wdata = wentry;
    end
  end

  assign raddr  = base_addr + AW'(lvl_q);
  assign rentry = rdata;

  nrcc_ram #(
    .WIDTH (nrcc_pkg::EntryW),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign dx      = 17'(q_coord_q.x) - 17'(rentry.x);
  assign dy      = 17'(q_coord_q.y) - 17'(rentry.y);
  assign dz      = $signed({2'b00, int_q}) - $signed({2'b00, rentry.z});
  assign dist_sq = 35'(sqx_q) + 35'(sqy_q) + 35'(sqz_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (32'(clr_q) == Depth - 1) state_d = StIdle;
      StIdle:  if (accept) state_d = StCyl;
      StCyl: begin
        if (cyl_done) begin
          state_d = (op_q && strip_ok) ? StRead : StRes;
        end
      end
      StRead:  state_d = StSq;
      StSq:    state_d = StCmp;
      StCmp:   state_d = last_lvl ? StRes : StRead;
      StRes:   if (!out_valid_q || m_axis_tready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == StRes && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tuser_i;
      strip_q <= s_axis_tdata_i[3:0];
      slot_q  <= s_axis_tdata_i[6:4];
      hue_q   <= s_axis_tdata_i[22:7];
      sat_q   <= s_axis_tdata_i[36:23];
      int_q   <= s_axis_tdata_i[51:37];
    end
    if (state_q == StCyl && cyl_done) begin
      q_coord_q   <= cyl_coord;
      lvl_q       <= '0;
      best_q      <= nrcc_pkg::LimitSq;
      res_level_q <= '0;
      res_match_q <= 1'b0;
    end
    if (state_q == StSq) begin
      sqx_q       <= 33'(dx * dx);
      sqy_q       <= 33'(dy * dy);
      sqz_q       <= 33'(dz * dz);
      ent_valid_q <= rentry.valid;
    end
    if (state_q == StCmp) begin
      // Strictly smaller only, so an earlier level wins a tie.
      if (ent_valid_q && (dist_sq < best_q)) begin
        best_q      <= dist_sq;
        res_level_q <= 3'(lvl_q);
        res_match_q <= 1'b1;
      end
      lvl_q <= lvl_q + LW'(1);
    end
    if (state_q == StRes && (!out_valid_q || m_axis_tready_i)) begin
      out_level_q <= res_level_q;
      out_match_q <= res_match_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_match_q, out_level_q};

endmodule

/* tb/nrcc_checker.sv */
// Checker for the color classifier: predicts each result from the input stream and compares.
`timescale 1ns / 1ps
module nrcc_checker #(
  parameter int unsigned NUM_STRIPS = 16,
  parameter int unsigned NUM_LEVELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [55:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          match_count_o
);

  typedef struct packed {
    logic [2:0] level;
    logic       matched;
  } verdict_t;

  logic [44:0] ref_colors [NUM_STRIPS*NUM_LEVELS];
  verdict_t    verdict_q [$];

  function automatic void octant_sincos(input longint unsigned r,
                                        output longint sn, output longint cs);
    longint unsigned x, x2, x3, x4, x5, x6, x7, x8;
    x  = r * longint'(nrcc_pkg::AngleStep);
    x2 = (x * x) >> 30;
    x3 = (x2 * x) >> 30;
    x4 = (x2 * x2) >> 30;
    x5 = (x4 * x) >> 30;
    x6 = (x4 * x2) >> 30;
    x7 = (x6 * x) >> 30;
    x8 = (x4 * x4) >> 30;
    sn = longint'(x) - longint'(x3 / 6) + longint'(x5 / 120) - longint'(x7 / 5040);
    cs = longint'(nrcc_pkg::OneQ30) - longint'(x2 / 2) + longint'(x4 / 24)
         - longint'(x6 / 720) + longint'(x8 / 40320);
  endfunction

  function automatic longint scale_hundredths(input longint unsigned s, input longint t);
    longint unsigned mag, v;
    mag = (t < 0) ? longint'(-t) : longint'(t);
    v = (s * mag + (64'd1 << 29)) >> 30;
    return (t < 0) ? -longint'(v) : longint'(v);
  endfunction

  function automatic void hsi_to_cylinder(input longint unsigned h, input longint unsigned s,
                                          output longint px, output longint py);
    longint a, b, sn, cs;
    longint unsigned q, r;
    if (h >= longint'(nrcc_pkg::FullTurn)) h = h - longint'(nrcc_pkg::FullTurn);
    q = h / 9000;
    r = h - q * 9000;
    if (r <= 4500) octant_sincos(r, a, b);
    else octant_sincos(9000 - r, b, a);
    case (q)
      0: begin sn = a;  cs = b;  end
      1: begin sn = b;  cs = -a; end
      2: begin sn = -a; cs = -b; end
      default: begin sn = -b; cs = a; end
    endcase
    px = scale_hundredths(s, cs);
    py = scale_hundredths(s, sn);
  endfunction

  function automatic verdict_t classify_color(input logic [3:0] strip, input logic [15:0] hue,
                                              input logic [13:0] sat, input logic [14:0] inten);
    verdict_t        res;
    longint          qx, qy, ex, ey, dx, dy, dz;
    longint unsigned best, d2;
    logic [44:0]     e;
    res = '0;
    best = longint'(nrcc_pkg::LimitSq);
    if (strip >= NUM_STRIPS) return res;
    hsi_to_cylinder(hue, sat, qx, qy);
    for (int j = 0; j < NUM_LEVELS; j++) begin
      e = ref_colors[strip*NUM_LEVELS + j];
      if (e != '0) begin
        hsi_to_cylinder(e[15:0], e[29:16], ex, ey);
        dx = qx - ex;
        dy = qy - ey;
        dz = longint'(inten) - longint'(e[44:30]);
        d2 = dx*dx + dy*dy + dz*dz;
        // Strictly smaller only, so a tie keeps the earlier level.
        if (d2 < best) begin
          best = d2;
          res.level = j[2:0];
          res.matched = 1'b1;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    match_count_o = 0;
    pending_o = 0;
    foreach (ref_colors[k]) ref_colors[k] = '0;
  end

  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_i) begin
      if (!s_axis_tuser_i) begin
        if (s_axis_tdata_i[3:0] < NUM_STRIPS && s_axis_tdata_i[6:4] < NUM_LEVELS)
          ref_colors[s_axis_tdata_i[3:0]*NUM_LEVELS + s_axis_tdata_i[6:4]] =
            s_axis_tdata_i[51:7];
        verdict_q.push_back(verdict_t'('0));
      end else begin
        verdict_q.push_back(classify_color(s_axis_tdata_i[3:0], s_axis_tdata_i[22:7],
                                           s_axis_tdata_i[36:23], s_axis_tdata_i[51:37]));
      end
    end
    if (rst_ni && m_axis_tvalid_i && m_axis_tready_i) begin
      got.level = m_axis_tdata_i[2:0];
      got.matched = m_axis_tdata_i[3];
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_i, -1);
      end else begin
        want = verdict_q.pop_front();
        if (got.matched) match_count_o++;
        if (got.matched != want.matched) report_mismatch("matched", got.matched, want.matched);
        if (got.level != want.level) report_mismatch("level", got.level, want.level);
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

/* tb/tb_nearest_reference_color_classifier.sv */
// Testbench top: drives writes and queries into the classifier and gives the verdict.
`timescale 1ns / 1ps
module tb_nearest_reference_color_classifier;

  localparam int unsigned NumStrips = 16;
  localparam int unsigned NumLevels = 8;
  localparam int          RandomItems = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;

  int fail_count, pending, match_count;
  int n_writes = 0, n_queries = 0;
  bit idle_on = 1'b0;
  bit holdoff_req = 1'b0;

  // Last written color per table entry, used only to aim queries near stored references.
  logic [15:0] last_hue [NumStrips*NumLevels];
  logic [13:0] last_sat [NumStrips*NumLevels];
  logic [14:0] last_int [NumStrips*NumLevels];

  always #2 clk_i = ~clk_i;

  nearest_reference_color_classifier #(
    .NUM_STRIPS(NumStrips), .NUM_LEVELS(NumLevels)
  ) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata)
  );

  nrcc_checker #(.NUM_STRIPS(NumStrips), .NUM_LEVELS(NumLevels)) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_i(m_tdata),
    .fail_count_o(fail_count), .pending_o(pending), .match_count_o(match_count)
  );

  // Fallback limit, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stall bursts while idling is on, plus one long hold-off on request.
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one transaction and return at the edge where it is accepted. The valid line is
  // only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_item(input logic op, input logic [3:0] strip, input logic [2:0] slot,
                           input logic [15:0] hue, input logic [13:0] sat,
                           input logic [14:0] inten);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, inten, sat, hue, slot, strip};
    @(negedge clk_i);
    while (!s_tready) @(negedge clk_i);
    @(posedge clk_i);
    if (op) begin
      n_queries++;
    end else begin
      n_writes++;
      last_hue[strip*NumLevels + slot] = hue;
      last_sat[strip*NumLevels + slot] = sat;
      last_int[strip*NumLevels + slot] = inten;
    end
  endtask

  initial begin
    int k;
    logic [3:0]  st;
    logic [2:0]  sl;
    logic [15:0] h;
    logic [13:0] sa;
    logic [14:0] in;
    foreach (last_hue[i]) begin
      last_hue[i] = '0; last_sat[i] = '0; last_int[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, both operations, ties, emptied entries, odd hues.
    send_item(1'b1, 4'd0, 3'd0, 16'd0, 14'd0, 15'd0);           // query on an empty strip
    send_item(1'b0, 4'd0, 3'd0, 16'd0, 14'd10000, 15'd25500);
    send_item(1'b0, 4'd0, 3'd1, 16'd0, 14'd10000, 15'd25500);   // same color, for a tie
    send_item(1'b1, 4'd0, 3'd7, 16'd0, 14'd10000, 15'd25500);
    send_item(1'b1, 4'd0, 3'd0, 16'd36000, 14'd10000, 15'd25500); // hue wraps past a turn
    send_item(1'b0, 4'd0, 3'd0, 16'd0, 14'd0, 15'd0);           // all-zero write empties
    send_item(1'b1, 4'd0, 3'd0, 16'd10, 14'd10000, 15'd25500);
    send_item(1'b0, 4'd15, 3'd7, 16'd35999, 14'd16383, 15'd32767);
    send_item(1'b1, 4'd15, 3'd0, 16'd65535, 14'd16383, 15'd32767);
    send_item(1'b1, 4'd15, 3'd0, 16'd35999, 14'd16383, 15'd32767);
    send_item(1'b0, 4'd5, 3'd2, 16'd4500, 14'd5000, 15'd100);
    send_item(1'b0, 4'd5, 3'd3, 16'd4501, 14'd5000, 15'd100);
    send_item(1'b0, 4'd5, 3'd4, 16'd9000, 14'd5000, 15'd100);
    send_item(1'b0, 4'd5, 3'd5, 16'd18000, 14'd5000, 15'd100);
    send_item(1'b0, 4'd5, 3'd6, 16'd27000, 14'd5000, 15'd100);
    send_item(1'b1, 4'd5, 3'd0, 16'd4500, 14'd5000, 15'd100);
    send_item(1'b1, 4'd5, 3'd0, 16'd4502, 14'd5000, 15'd100);
    send_item(1'b1, 4'd5, 3'd0, 16'd27050, 14'd5000, 15'd1000);  // well inside the limit
    send_item(1'b1, 4'd5, 3'd0, 16'd13500, 14'd5000, 15'd100);   // equidistant point
    send_item(1'b0, 4'd9, 3'd0, 16'd12345, 14'd0, 15'd0);       // hue only, still non-empty
    send_item(1'b1, 4'd9, 3'd0, 16'd0, 14'd0, 15'd0);

    // Random part: mostly queries aimed near stored references, plus writes and noise.
    idle_on = 1'b1;
    for (k = 0; k < RandomItems; k++) begin
      if (k == RandomItems / 2) holdoff_req = 1'b1;
      if (k == RandomItems - 200) idle_on = 1'b0;
      st = 4'($urandom_range(0, 15));
      sl = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          h  = 16'($urandom_range(0, 35999));
          sa = 14'($urandom_range(0, 10000));
          in = 15'($urandom_range(0, 25500));
          send_item(1'b0, st, sl, h, sa, in);
        end
        3: send_item(1'($urandom_range(0, 1)), st, sl, 16'($urandom), 14'($urandom),
                     15'($urandom));
        default: begin
          h  = 16'(last_hue[st*NumLevels + sl] + $urandom_range(0, 1200) - 600);
          sa = 14'(last_sat[st*NumLevels + sl] + $urandom_range(0, 800) - 400);
          in = 15'(last_int[st*NumLevels + sl] + $urandom_range(0, 1000) - 500);
          send_item(1'b1, st, 3'($urandom), h, sa, in);
        end
      endcase
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Covered %0d reference writes and %0d color queries, %0d of them matched,",
             n_writes, n_queries, match_count);
    $display("with random stalls on both sides and one long result hold-off.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
